// ===== rtl/core/priority_event_queue_top_defines.svh =====
// Assertion macros shared by the RTL of the event queue.
`ifndef PRIORITY_EVENT_QUEUE_TOP_DEFINES_SVH
`define PRIORITY_EVENT_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event queue check failed");

// Next-cycle implication, checked out of reset.
`define PEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event queue check failed");

`endif

// ===== rtl/core/peq_pkg.sv =====
`default_nettype none
package peq_pkg;

  localparam int NUM_LEVELS      = 8;
  localparam int SLOTS_PER_LEVEL = 8;
  localparam int NUM_TASKS       = 8;
  localparam int EVENT_BITS      = 16;

  localparam int TASK_W   = 3;
  localparam int LVL_W    = 3;
  localparam int DEPTH_W  = 4;
  localparam int TCNT_W   = DEPTH_W + 1;
  localparam int PTR_W    = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
  localparam int LCNT_W   = $clog2(SLOTS_PER_LEVEL + 1);
  localparam int SLOTS    = NUM_LEVELS * SLOTS_PER_LEVEL;
  localparam int SADDR_W  = $clog2(SLOTS);
  localparam int ENTRY_W  = EVENT_BITS + TASK_W;

  localparam int PRIO_MAP_W  = 24;
  localparam int DEPTH_MAP_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIO_MAP  = 2'd0,
    REG_DEPTH_MAP = 2'd1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_POSTED     = 3'd0,
    ST_DROPPED    = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_STALE      = 3'd3,
    ST_DISPATCHED = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RD   = 1'b1
  } state_t;

  typedef struct packed {
    status_t               status;
    logic [TASK_W-1:0]     task_id;
    logic [EVENT_BITS-1:0] event_handle;
    logic                  pend;
    logic [LVL_W-1:0]      pend_level;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/priority_event_queue_top.sv =====
// Timing: a post or an activate of an empty level shows its result in the cycle after its beat;
//   an activate that pops a slot first passes the slot RAM read register and the S_RD state.
// Throughput: one post per cycle; a popping activate holds off the input during S_RD. The input
//   takes a beat while the FSM is idle and the output register is free or being drained.
// Reset (rst_n low, synchronous): clear both maps, all ring pointers and counters, and the
//   output valid; slot RAM contents are left as they are and need no clearing pass.
`default_nettype none
`include "priority_event_queue_top_defines.svh"
module priority_event_queue_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: task_id[2:0], level[5:3], event_handle[21:6], zero pad [23:22]
  input  wire logic [peq_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: kind (0 post, 1 activate)
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: out_task[2:0], out_event[18:3], pend[19], pend_level[22:20], zero pad [23]
  output logic      [peq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser: status[2:0]
  output logic      [peq_pkg::STATUS_W-1:0]      out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [peq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [peq_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import peq_pkg::*;

  // Configuration registers
  logic [PRIO_MAP_W-1:0]  prio_map_r;
  logic [DEPTH_MAP_W-1:0] depth_map_r;

  // Per-level ring state and per-task pending counters
  logic [PTR_W-1:0]  wr_ptr_r    [NUM_LEVELS];
  logic [PTR_W-1:0]  rd_ptr_r    [NUM_LEVELS];
  logic [LCNT_W-1:0] lvl_cnt_r   [NUM_LEVELS];
  logic [TCNT_W-1:0] task_cnt_r  [NUM_TASKS];

  state_t           state_r, state_nxt;
  logic [LVL_W-1:0] act_lvl_r;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;

  // Input beat decode
  logic                  in_beat;
  logic                  is_act;
  logic [TASK_W-1:0]     in_task;
  logic [LVL_W-1:0]      in_lvl;
  logic [EVENT_BITS-1:0] in_ev;

  // Post path
  logic [LVL_W-1:0]   post_lvl;
  logic [DEPTH_W-1:0] post_depth_m1;
  logic               post_ok;

  // Activate path
  logic act_ok;

  // Slot RAM
  logic               ram_we, ram_re;
  logic [SADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Pop result
  logic [TASK_W-1:0]     pop_task;
  logic [EVENT_BITS-1:0] pop_ev;
  logic                  pop_stale;
  logic [TCNT_W-1:0]     pop_left;

  logic load_out;

  assign cfg_ready = 1'b1;

  assign in_beat = in_tvalid && in_tready;
  assign is_act  = in_tuser;
  assign in_task = in_tdata[TASK_W-1:0];
  assign in_lvl  = in_tdata[TASK_W +: LVL_W];
  assign in_ev   = in_tdata[TASK_W+LVL_W +: EVENT_BITS];

  // Look up the task's level and depth from the maps
  assign post_lvl      = prio_map_r[LVL_W*in_task +: LVL_W];
  assign post_depth_m1 = depth_map_r[DEPTH_W*in_task +: DEPTH_W];
  assign post_ok = (int'(in_task) < NUM_TASKS) && (int'(post_lvl) < NUM_LEVELS)
                && (int'(lvl_cnt_r[post_lvl]) < SLOTS_PER_LEVEL)
                && (task_cnt_r[in_task] <= TCNT_W'(post_depth_m1));

  assign act_ok = (int'(in_lvl) < NUM_LEVELS) && (lvl_cnt_r[in_lvl] != '0);

  assign pop_task  = ram_rdata[TASK_W-1:0];
  assign pop_ev    = ram_rdata[TASK_W +: EVENT_BITS];
  assign pop_stale = !(int'(pop_task) < NUM_TASKS) || (task_cnt_r[pop_task] == '0);
  assign pop_left  = task_cnt_r[pop_task] - TCNT_W'(1);

  // Slot RAM ports: write on an accepted post, read on a popping activate
  assign ram_waddr = SADDR_W'(int'(post_lvl) * SLOTS_PER_LEVEL + int'(wr_ptr_r[post_lvl]));
  assign ram_raddr = SADDR_W'(int'(in_lvl) * SLOTS_PER_LEVEL + int'(rd_ptr_r[in_lvl]));
  assign ram_wdata = {in_ev, in_task};

  peq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [PTR_W-1:0] ptr_down(input logic [PTR_W-1:0] p);
    ptr_down = (p == '0) ? PTR_W'(SLOTS_PER_LEVEL - 1) : p - PTR_W'(1);
  endfunction

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat && is_act && act_ok) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs: take a beat only when idle and the output register can take a result
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        ram_we    = in_beat && !is_act && post_ok;
        ram_re    = in_beat && is_act && act_ok;
        load_out  = in_beat && !(is_act && act_ok);
      end
      S_RD: begin
        load_out = 1'b1;
      end
      default: ;
    endcase
  end

  // Result to load into the output register
  always_comb begin
    out_res_nxt = '{status: ST_DROPPED, task_id: '0, event_handle: '0,
                    pend: 1'b0, pend_level: '0};
    if (state_r == S_RD) begin
      if (pop_stale) begin
        out_res_nxt.status = ST_STALE;
      end else begin
        out_res_nxt.status       = ST_DISPATCHED;
        out_res_nxt.task_id      = pop_task;
        out_res_nxt.event_handle = pop_ev;
        out_res_nxt.pend         = (pop_left != '0);
        out_res_nxt.pend_level   = (pop_left != '0) ? act_lvl_r : '0;
      end
    end else if (is_act) begin
      out_res_nxt.status = ST_EMPTY;
    end else if (post_ok) begin
      out_res_nxt.status     = ST_POSTED;
      out_res_nxt.pend       = 1'b1;
      out_res_nxt.pend_level = post_lvl;
    end
  end

  // Hold the result until the sink takes it
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prio_map_r  <= '0;
      depth_map_r <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        wr_ptr_r[i]  <= '0;
        rd_ptr_r[i]  <= '0;
        lvl_cnt_r[i] <= '0;
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
        task_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRIO_MAP:  prio_map_r  <= cfg_data[PRIO_MAP_W-1:0];
          REG_DEPTH_MAP: depth_map_r <= cfg_data[DEPTH_MAP_W-1:0];
          default: ;
        endcase
      end

      // Post: advance the write pointer, raise both counts
      if (ram_we) begin
        wr_ptr_r[post_lvl]  <= ptr_down(wr_ptr_r[post_lvl]);
        lvl_cnt_r[post_lvl] <= lvl_cnt_r[post_lvl] + LCNT_W'(1);
        task_cnt_r[in_task] <= task_cnt_r[in_task] + TCNT_W'(1);
      end

      // Activate: consume the slot now, settle the task count once the data is back
      if (ram_re) begin
        rd_ptr_r[in_lvl]  <= ptr_down(rd_ptr_r[in_lvl]);
        lvl_cnt_r[in_lvl] <= lvl_cnt_r[in_lvl] - LCNT_W'(1);
      end
      if (state_r == S_RD && !pop_stale) begin
        task_cnt_r[pop_task] <= pop_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      act_lvl_r <= in_lvl;
    end
    if (load_out) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = OUT_DATA_W'({out_res_r.pend_level, out_res_r.pend,
                                   out_res_r.event_handle, out_res_r.task_id});

  // A popping activate always goes through the RAM read state
  `PEQ_ASSERT_NEXT(a_pop_reads, clk, rst_n, in_beat && is_act && act_ok, state_r == S_RD)
  // The output register is free while a pop waits on the RAM
  `PEQ_ASSERT_NOW(a_rd_out_free, clk, rst_n, state_r == S_RD, !out_valid_r)
  // Only a dispatch carries a task and an event
  `PEQ_ASSERT_NOW(a_payload_clean, clk, rst_n,
    out_tvalid && (out_tuser != ST_DISPATCHED),
    (out_res_r.task_id == '0) && (out_res_r.event_handle == '0))

endmodule
`default_nettype wire

// ===== rtl/core/peq_ram.sv =====
`default_nettype none
module peq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== tb/event_queue_checker.sv =====
`timescale 1ns / 100ps
module event_queue_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [peq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tuser,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [peq_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic [peq_pkg::STATUS_W-1:0]   out_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [peq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [peq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  fail_count,
  output int                                  outstanding
);
  import peq_pkg::*;

  logic [TASK_W-1:0]      ring_task  [NUM_LEVELS][SLOTS_PER_LEVEL];
  logic [EVENT_BITS-1:0]  ring_event [NUM_LEVELS][SLOTS_PER_LEVEL];
  logic [PTR_W-1:0]       wr_ptr [NUM_LEVELS];
  logic [PTR_W-1:0]       rd_ptr [NUM_LEVELS];
  int                     ring_fill [NUM_LEVELS];
  int                     task_pending [NUM_TASKS];
  logic [PRIO_MAP_W-1:0]  prio_map;
  logic [DEPTH_MAP_W-1:0] depth_map;

  result_t due_outcomes[$];

  function automatic logic [PTR_W-1:0] ptr_down(logic [PTR_W-1:0] p);
    return (p == 0) ? PTR_W'(SLOTS_PER_LEVEL - 1) : p - 1'b1;
  endfunction

  // Apply one post or activate to the ring state and return its outcome.
  function automatic result_t queue_engine_step(logic activate, logic [TASK_W-1:0] tid,
                                                logic [LVL_W-1:0] lvl,
                                                logic [EVENT_BITS-1:0] ev);
    result_t r;
    int lv;
    int depth;
    int t;
    logic [EVENT_BITS-1:0] e;
    r = '0;
    if (!activate) begin
      r.status = ST_DROPPED;
      if (int'(tid) < NUM_TASKS) begin
        lv    = int'(prio_map[tid*LVL_W +: LVL_W]);
        depth = int'(depth_map[tid*DEPTH_W +: DEPTH_W]) + 1;
        if (lv < NUM_LEVELS && ring_fill[lv] < SLOTS_PER_LEVEL &&
            task_pending[tid] < depth) begin
          ring_task[lv][wr_ptr[lv]]  = tid;
          ring_event[lv][wr_ptr[lv]] = ev;
          wr_ptr[lv] = ptr_down(wr_ptr[lv]);
          ring_fill[lv]++;
          task_pending[tid]++;
          r.status     = ST_POSTED;
          r.pend       = 1'b1;
          r.pend_level = LVL_W'(lv);
        end
      end
    end else if (int'(lvl) >= NUM_LEVELS || ring_fill[lvl] == 0) begin
      r.status = ST_EMPTY;
    end else begin
      t = int'(ring_task[lvl][rd_ptr[lvl]]);
      e = ring_event[lvl][rd_ptr[lvl]];
      rd_ptr[lvl] = ptr_down(rd_ptr[lvl]);
      ring_fill[lvl]--;
      if (t >= NUM_TASKS || task_pending[t] == 0) begin
        r.status = ST_STALE;
      end else begin
        task_pending[t]--;
        r.status       = ST_DISPATCHED;
        r.task_id      = TASK_W'(t);
        r.event_handle = e;
        r.pend         = (task_pending[t] > 0);
        r.pend_level   = r.pend ? lvl : '0;
      end
    end
    return r;
  endfunction

  task automatic flag_error(string msg);
    fail_count++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [EVENT_BITS-1:0] want,
                             logic [EVENT_BITS-1:0] got);
    if (got !== want) flag_error($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      prio_map   = '0;
      depth_map  = '0;
      fail_count = 0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        wr_ptr[l]    = '0;
        rd_ptr[l]    = '0;
        ring_fill[l] = 0;
      end
      for (int t = 0; t < NUM_TASKS; t++) task_pending[t] = 0;
      due_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRIO_MAP:  prio_map  = cfg_data[PRIO_MAP_W-1:0];
          REG_DEPTH_MAP: depth_map = cfg_data[DEPTH_MAP_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (due_outcomes.size() == 0) begin
          flag_error("result beat with nothing due");
        end else begin
          want = due_outcomes.pop_front();
          check_field("status", EVENT_BITS'(want.status), EVENT_BITS'(out_tuser));
          check_field("out_task", EVENT_BITS'(want.task_id), EVENT_BITS'(out_tdata[2:0]));
          check_field("out_event", want.event_handle, out_tdata[18:3]);
          check_field("pend", EVENT_BITS'(want.pend), EVENT_BITS'(out_tdata[19]));
          check_field("pend_level", EVENT_BITS'(want.pend_level),
                      EVENT_BITS'(out_tdata[22:20]));
        end
      end
      if (in_tvalid && in_tready)
        due_outcomes.push_back(queue_engine_step(in_tuser, in_tdata[2:0], in_tdata[5:3],
                                                 in_tdata[21:6]));
    end
    outstanding = due_outcomes.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import peq_pkg::*;

  // Item kinds carried on in_tuser
  localparam logic KIND_POST     = 1'b0;
  localparam logic KIND_ACTIVATE = 1'b1;

  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_CYCLES     = 400;     // long receiver hold-off
  localparam int SETTLE_CYCLES   = 6;       // idle time after the last result
  localparam int LIMIT_CYCLES    = 400_000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;   // task_id[2:0], level[5:3], event_handle[21:6], pad
  logic                  in_tuser;   // kind
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // out_task[2:0], out_event[18:3], pend[19],
                                     // pend_level[22:20], pad
  logic [STATUS_W-1:0]   out_tuser;  // status
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int outstanding;
  int items_sent = 0;
  int burst_left = 0;
  int cycles     = 0;

  always #5 clk = ~clk;

  priority_event_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  event_queue_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Watchdog: end the run, reporting errors, once the cycle limit is reached.
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one beat from a falling edge, hold it until taken, then return on a falling
  // edge. Valid stays high across a burst; between bursts drop it for a random gap.
  task automatic push_beat(logic kind, logic [TASK_W-1:0] tid, logic [LVL_W-1:0] lvl,
                           logic [EVENT_BITS-1:0] ev);
    in_tuser  = kind;
    in_tdata  = {2'b00, ev, lvl, tid};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      // mostly short bursts, now and then a long unbroken one
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Stop offering beats, wait for every due result, then let the pipeline settle.
  task automatic quiesce();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: switch between always-ready, coin-flip and mostly-stalled spans. Twice
  // during the run hold off for a long stretch so the block backs up into its input.
  initial begin
    int span;
    int mode;
    int hold_at;
    out_tready = 1'b0;
    hold_at    = 500;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 150);
      repeat (span) begin
        if (items_sent >= hold_at) begin
          out_tready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_at += 900;
        end
        case (mode)
          0:       out_tready = 1'b1;
          1:       out_tready = 1'($urandom_range(0, 1));
          default: out_tready = ($urandom_range(0, 3) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [PRIO_MAP_W-1:0]  ident_map;
    logic [PRIO_MAP_W-1:0]  prio;
    logic [DEPTH_MAP_W-1:0] depth;
    int                     spread;
    int                     tsel;

    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_POST;
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_PRIO_MAP;
    cfg_data  = '0;
    for (int t = 0; t < NUM_TASKS; t++) ident_map[t*LVL_W +: LVL_W] = LVL_W'(t);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: task t on level t, task 1 deep (16), all others one deep.
    write_reg(REG_PRIO_MAP, CFG_DATA_W'(ident_map));
    write_reg(REG_DEPTH_MAP, 32'h0000_00F0);
    burst_left = 30;
    push_beat(KIND_ACTIVATE, 3'd0, 3'd0, 16'h0000);   // empty level, lowest
    push_beat(KIND_ACTIVATE, 3'd7, 3'd7, 16'hFFFF);   // empty level, highest
    push_beat(KIND_POST,     3'd0, 3'd0, 16'h0000);
    push_beat(KIND_POST,     3'd0, 3'd7, 16'hFFFF);   // task already at its depth
    push_beat(KIND_ACTIVATE, 3'd0, 3'd0, 16'h0000);
    push_beat(KIND_POST,     3'd7, 3'd7, 16'hFFFF);
    push_beat(KIND_ACTIVATE, 3'd5, 3'd7, 16'h0000);
    // fill level 1 past its ring size, then drain it dry
    for (int i = 0; i < SLOTS_PER_LEVEL + 1; i++)
      push_beat(KIND_POST, 3'd1, 3'(i), 16'(16'h1111 * i + 16'h0F0F));
    for (int i = 0; i < SLOTS_PER_LEVEL + 1; i++)
      push_beat(KIND_ACTIVATE, 3'(i), 3'd1, 16'(~i));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiesce();
      case (ph)
        0: begin
          prio  = '0;
          depth = '0;
        end
        1: begin
          prio  = '1;
          depth = '1;
        end
        2: begin
          prio  = ident_map;
          depth = $urandom;
        end
        default: begin
          // crowd tasks onto a few levels so rings fill and pend chains get long
          spread = $urandom_range(0, NUM_LEVELS - 1);
          for (int t = 0; t < NUM_TASKS; t++)
            prio[t*LVL_W +: LVL_W] = LVL_W'($urandom_range(0, spread));
          depth = $urandom;
        end
      endcase
      write_reg(REG_PRIO_MAP, CFG_DATA_W'(prio));
      write_reg(REG_DEPTH_MAP, depth);

      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 55) begin
          push_beat(KIND_POST, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    16'($urandom));
        end else begin
          // mostly service a level that some task feeds; sometimes any level
          tsel = $urandom_range(0, NUM_TASKS - 1);
          push_beat(KIND_ACTIVATE, 3'($urandom_range(0, 7)),
                    ($urandom_range(0, 99) < 85) ? prio[tsel*LVL_W +: LVL_W]
                                                 : 3'($urandom_range(0, 7)),
                    16'($urandom));
        end
      end
    end

    quiesce();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
